>>> rtl/core/queued_lock_with_condition_macros.svh
// Assertion macros used by the queued lock RTL
`ifndef QUEUED_LOCK_WITH_CONDITION_MACROS_SVH
`define QUEUED_LOCK_WITH_CONDITION_MACROS_SVH

`ifndef SYNTHESIS
`define QLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define QLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QLC_ASSERT_IMP(lbl, ante, cons, msg)
`define QLC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/qlc_pkg.sv
// Types, codes and helpers of the queued lock
`timescale 1ns / 1ps
package qlc_pkg;

  localparam int DefRequesters = 64;
  localparam int ReqIdW        = 6;
  localparam int ReqIdCount    = 1 << ReqIdW;
  localparam int MaxIdW        = 10;
  localparam int CountW        = 7;

  typedef enum logic [2:0] {
    REQ_ACQUIRE  = 3'd0,
    REQ_TRY      = 3'd1,
    REQ_RELEASE  = 3'd2,
    REQ_SLEEP    = 3'd3,
    REQ_WAKEUP   = 3'd4,
    REQ_WAKE_ALL = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    STAT_ACQUIRED        = 3'd0,
    STAT_QUEUED          = 3'd1,
    STAT_NOT_ACQUIRED    = 3'd2,
    STAT_DONE            = 3'd3,
    STAT_NOT_LOCKED      = 3'd4,
    STAT_ALREADY_WAITING = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    MARK_FREE  = 2'd0,
    MARK_LOCKQ = 2'd1,
    MARK_CONDQ = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WAKE,
    ST_FIN
  } state_e;

  typedef logic [MaxIdW-1:0] wrap_lut_t [ReqIdCount];

  // Requester code to identity, wrapping at n
  function automatic wrap_lut_t wrap_lut(input int n);
    wrap_lut_t lut;
    int r;
    r = 0;
    for (int i = 0; i < ReqIdCount; i++) begin
      lut[i] = MaxIdW'(r);
      r = (r + 1 == n) ? 0 : r + 1;
    end
    return lut;
  endfunction

endpackage

>>> rtl/core/queued_lock_with_condition.sv
// Top level of the queued lock (FIFO for acquirers) with one condition queue
`timescale 1ns / 1ps
`include "queued_lock_with_condition_macros.svh"
// Start an item with start high while busy is low. Acquire, try, release, unknown
// codes and every request that ends in an error finish from the execute state;
// a successful sleep goes on to a finish state because the wait-mark memory has one
// write port. Wakeup and wakeup all go on to the wake state, where the sequencer
// walks the condition queue through the link memory one entry a cycle, moving one
// sleeper per entry. Each result shows for one cycle with result_valid_o high and
// cannot be stalled; a new item may be started in that same cycle. After reset the
// block clears every entry of the wait-mark memory with busy high.
module queued_lock_with_condition
  import qlc_pkg::*;
#(
  parameter int REQUESTERS = DefRequesters
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [5:0]  requester_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic        handoff_valid_o,
  output logic [5:0]  handoff_id_o,
  output logic [6:0]  woken_count_o
);

  localparam int IdW  = $clog2(REQUESTERS);
  localparam int CntW = $clog2(REQUESTERS + 1);
  localparam logic [IdW-1:0] LastId = IdW'(REQUESTERS - 1);
  localparam wrap_lut_t WrapLut = wrap_lut(REQUESTERS);

  state_e state_q, state_d;
  logic            held_q, held_d;
  logic [IdW-1:0]  lq_head_q, lq_head_d, lq_tail_q, lq_tail_d;
  logic            lq_ne_q, lq_ne_d;
  logic [IdW-1:0]  cq_head_q, cq_head_d, cq_tail_q, cq_tail_d;
  logic            cq_ne_q, cq_ne_d;
  logic [IdW-1:0]  clr_q, clr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rv_q, rv_d;
  req_e            type_q, type_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [IdW-1:0]  pend_q, pend_d;
  status_e         status_q, status_d;
  logic            hv_q, hv_d;
  logic [IdW-1:0]  hid_q, hid_d;

  logic [IdW-1:0]  id_in;
  logic            accept;
  logic            wake_go;
  logic            pass_en;

  logic            link_we;
  logic [IdW-1:0]  link_waddr, link_wdata, link_raddr, link_rd;
  logic            mark_we;
  logic [IdW-1:0]  mark_waddr;
  mark_e           mark_wdata, mark_rd;

  qlc_store #(
    .Depth(REQUESTERS),
    .IdW  (IdW)
  ) u_store (
    .clk_i       (clk_i),
    .link_we_i   (link_we),
    .link_waddr_i(link_waddr),
    .link_wdata_i(link_wdata),
    .link_raddr_i(link_raddr),
    .link_rdata_o(link_rd),
    .mark_we_i   (mark_we),
    .mark_waddr_i(mark_waddr),
    .mark_wdata_i(mark_wdata),
    .mark_raddr_i(id_in),
    .mark_rdata_o(mark_rd)
  );

  assign id_in   = WrapLut[requester_i][IdW-1:0];
  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  // a single wakeup stops after one sleeper
  assign wake_go = cq_ne_q && !(type_q == REQ_WAKEUP && cnt_q != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastId) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (held_q && (type_q == REQ_WAKEUP || type_q == REQ_WAKE_ALL)) begin
          state_d = ST_WAKE;
        end else if (held_q && type_q == REQ_SLEEP && mark_rd == MARK_FREE) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WAKE: begin
        if (!wake_go) state_d = ST_IDLE;
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    held_d    = held_q;
    lq_head_d = lq_head_q;
    lq_tail_d = lq_tail_q;
    lq_ne_d   = lq_ne_q;
    cq_head_d = cq_head_q;
    cq_tail_d = cq_tail_q;
    cq_ne_d   = cq_ne_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    rv_d      = 1'b0;
    type_d    = type_q;
    id_d      = id_q;
    pend_d    = pend_q;
    status_d  = status_q;
    hv_d      = hv_q;
    hid_d     = hid_q;
    pass_en   = 1'b0;

    link_we    = 1'b0;
    link_waddr = lq_tail_q;
    link_wdata = id_q;
    link_raddr = lq_head_q;
    mark_we    = 1'b0;
    mark_waddr = id_q;
    mark_wdata = MARK_FREE;

    case (state_q)
      ST_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
      end
      ST_IDLE: begin
        // look up the head that a release, sleep or wakeup will need
        if (req_type_i == REQ_RELEASE || req_type_i == REQ_SLEEP) begin
          link_raddr = lq_head_q;
        end else begin
          link_raddr = cq_head_q;
        end
        if (accept) begin
          type_d = req_e'(req_type_i);
          id_d   = id_in;
        end
      end
      ST_EXEC: begin
        // hold the link of the head sleeper for the first wake step
        link_raddr = cq_head_q;
        status_d = STAT_DONE;
        hv_d     = 1'b0;
        hid_d    = '0;
        cnt_d    = '0;
        rv_d     = 1'b1;
        case (type_q)
          REQ_ACQUIRE, REQ_TRY: begin
            if (mark_rd != MARK_FREE) begin
              status_d = STAT_ALREADY_WAITING;
            end else if (!held_q) begin
              held_d   = 1'b1;
              status_d = STAT_ACQUIRED;
            end else if (type_q == REQ_TRY) begin
              status_d = STAT_NOT_ACQUIRED;
            end else begin
              if (lq_ne_q) begin
                link_we    = 1'b1;
                link_waddr = lq_tail_q;
                link_wdata = id_q;
              end else begin
                lq_head_d = id_q;
              end
              lq_tail_d  = id_q;
              lq_ne_d    = 1'b1;
              mark_we    = 1'b1;
              mark_waddr = id_q;
              mark_wdata = MARK_LOCKQ;
              status_d   = STAT_QUEUED;
            end
          end
          REQ_RELEASE: begin
            if (!held_q) begin
              status_d = STAT_NOT_LOCKED;
            end else begin
              pass_en = 1'b1;
            end
          end
          REQ_SLEEP: begin
            if (!held_q) begin
              status_d = STAT_NOT_LOCKED;
            end else if (mark_rd != MARK_FREE) begin
              status_d = STAT_ALREADY_WAITING;
            end else begin
              if (cq_ne_q) begin
                link_we    = 1'b1;
                link_waddr = cq_tail_q;
                link_wdata = id_q;
              end else begin
                cq_head_d = id_q;
              end
              cq_tail_d  = id_q;
              cq_ne_d    = 1'b1;
              mark_we    = 1'b1;
              mark_waddr = id_q;
              mark_wdata = MARK_CONDQ;
              status_d   = STAT_QUEUED;
              pass_en    = 1'b1;
              rv_d       = 1'b0;
            end
          end
          REQ_WAKEUP, REQ_WAKE_ALL: begin
            if (!held_q) begin
              status_d = STAT_NOT_LOCKED;
            end else begin
              rv_d = 1'b0;
            end
          end
          default: ;
        endcase

        // hand the lock to the head waiter, or free it
        if (pass_en) begin
          if (!lq_ne_q) begin
            held_d = 1'b0;
          end else begin
            if (lq_head_q == lq_tail_q) begin
              lq_ne_d = 1'b0;
            end else begin
              lq_head_d = link_rd;
            end
            hv_d   = 1'b1;
            hid_d  = lq_head_q;
            pend_d = lq_head_q;
            if (type_q == REQ_RELEASE) begin
              mark_we    = 1'b1;
              mark_waddr = lq_head_q;
              mark_wdata = MARK_FREE;
            end
          end
        end
      end
      ST_WAKE: begin
        // fetch the link of the next sleeper while moving this one
        link_raddr = link_rd;
        if (wake_go) begin
          if (cq_head_q == cq_tail_q) begin
            cq_ne_d = 1'b0;
          end else begin
            cq_head_d = link_rd;
          end
          if (lq_ne_q) begin
            link_we    = 1'b1;
            link_waddr = cq_head_q;
            link_wdata = lq_head_q;
          end else begin
            lq_tail_d = cq_head_q;
            lq_ne_d   = 1'b1;
          end
          lq_head_d  = cq_head_q;
          mark_we    = 1'b1;
          mark_waddr = cq_head_q;
          mark_wdata = MARK_LOCKQ;
          cnt_d      = cnt_q + 1'b1;
        end else begin
          rv_d = 1'b1;
        end
      end
      ST_FIN: begin
        // free the mark of the requester that took the lock
        if (hv_q) begin
          mark_we    = 1'b1;
          mark_waddr = pend_q;
          mark_wdata = MARK_FREE;
        end
        rv_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      held_q    <= 1'b0;
      lq_head_q <= '0;
      lq_tail_q <= '0;
      lq_ne_q   <= 1'b0;
      cq_head_q <= '0;
      cq_tail_q <= '0;
      cq_ne_q   <= 1'b0;
      clr_q     <= '0;
      cnt_q     <= '0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      lq_head_q <= lq_head_d;
      lq_tail_q <= lq_tail_d;
      lq_ne_q   <= lq_ne_d;
      cq_head_q <= cq_head_d;
      cq_tail_q <= cq_tail_d;
      cq_ne_q   <= cq_ne_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q   <= type_d;
    id_q     <= id_d;
    pend_q   <= pend_d;
    status_q <= status_d;
    hv_q     <= hv_d;
    hid_q    <= hid_d;
  end

  assign result_valid_o  = rv_q;
  assign status_o        = status_q;
  assign handoff_valid_o = hv_q;
  assign handoff_id_o    = 6'(hid_q);
  assign woken_count_o   = 7'(cnt_q);

  `QLC_ASSERT_IMP(a_waiters_need_holder, !held_q, !lq_ne_q, "lock queue busy with lock free")
  `QLC_ASSERT_IMP(a_handoff_status, result_valid_o && handoff_valid_o, status_o == STAT_DONE || status_o == STAT_QUEUED, "handoff with wrong status")
  `QLC_ASSERT_IMP(a_woken_queued, result_valid_o && woken_count_o != '0, lq_ne_q, "woken sleepers missing from lock queue")
  `QLC_ASSERT_NXT(a_try_takes_free, state_q == ST_EXEC && type_q == REQ_TRY && !held_q && mark_rd == MARK_FREE, held_q && status_o == STAT_ACQUIRED, "try on free lock not taken")

endmodule

>>> rtl/core/qlc_store.sv
// Link and wait-mark memories of the queued lock
`timescale 1ns / 1ps
module qlc_store
  import qlc_pkg::*;
#(
  parameter int Depth = DefRequesters,
  parameter int IdW   = $clog2(DefRequesters)
) (
  input  logic           clk_i,
  input  logic           link_we_i,
  input  logic [IdW-1:0] link_waddr_i,
  input  logic [IdW-1:0] link_wdata_i,
  input  logic [IdW-1:0] link_raddr_i,
  output logic [IdW-1:0] link_rdata_o,
  input  logic           mark_we_i,
  input  logic [IdW-1:0] mark_waddr_i,
  input  mark_e          mark_wdata_i,
  input  logic [IdW-1:0] mark_raddr_i,
  output mark_e          mark_rdata_o
);

  logic [IdW-1:0] link_mem [Depth];
  logic [1:0]     mark_mem [Depth];
  logic [1:0]     mark_rd_q;

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    link_rdata_o <= link_mem[link_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we_i) begin
      mark_mem[mark_waddr_i] <= mark_wdata_i;
    end
    mark_rd_q <= mark_mem[mark_raddr_i];
  end

  assign mark_rdata_o = mark_e'(mark_rd_q);

endmodule
